/* hdl/efpsc_pkg.sv */
package efpsc_pkg;

  localparam int unsigned MaxFrame = 256;
  localparam int unsigned MinFrame = 5;

  localparam logic [7:0] EscByte     = 8'h55;
  localparam logic [7:0] StuffedSync = 8'hA5;

  localparam logic [7:0] SyncReset   = 8'hA5;
  localparam logic [7:0] IdReset     = 8'h00;
  localparam logic [7:0] LengthReset = 8'h00;
  localparam logic [8:0] FrameReset  = 9'd64;

  localparam int unsigned AddrWidth = 4;

  typedef enum logic [1:0] {
    RegSync   = 2'd0,
    RegId     = 2'd1,
    RegLength = 2'd2,
    RegFrame  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    PhHunt    = 3'd0,
    PhSync    = 3'd1,
    PhId      = 3'd2,
    PhPayload = 3'd3,
    PhCheck   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindGood    = 2'd1,
    KindBad     = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] id_value;
    logic [7:0] length_value;
    logic [8:0] frame_bytes;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] position;
    logic [7:0] computed_sum;
    logic       last;
  } result_t;

endpackage

/* hdl/escaped_frame_parser_sum_check.sv */
// Channel   Direction  Beat contents
// s_axis    in         tdata[7:0] rx_byte
// m_axis    out        tdata data_byte, position, computed_sum; tuser kind; tlast last
// apb       in         sync_value, id_value, length_value, frame_bytes at 0x0, 0x4, 0x8, 0xC
//
// One byte a cycle unless the output stalls: a beat lands in the input register, is parsed
// once the output register can take its result and, when it yields a result, is held in the
// output register until taken. The output register sets the rate.
// Reset returns the parser to the sync hunt and restores the register reset values.
// A stalled output register holds the parse stage, which holds the input register.
module escaped_frame_parser_sum_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // [7:0] data_byte, [15:8] position,
                                                         // [23:16] computed_sum
  output logic [1:0]                      m_axis_tuser,  // [1:0] kind
  output logic                            m_axis_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [efpsc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  efpsc_pkg::cfg_t    cfg_q;
  efpsc_pkg::result_t res;
  efpsc_pkg::result_t out_q;
  efpsc_pkg::reg_idx_e reg_idx;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       advance;
  logic       res_valid;

  assign pready  = 1'b1;
  assign reg_idx = efpsc_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value   <= efpsc_pkg::SyncReset;
      cfg_q.id_value     <= efpsc_pkg::IdReset;
      cfg_q.length_value <= efpsc_pkg::LengthReset;
      cfg_q.frame_bytes  <= efpsc_pkg::FrameReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        efpsc_pkg::RegSync:   cfg_q.sync_value   <= pwdata[7:0];
        efpsc_pkg::RegId:     cfg_q.id_value     <= pwdata[7:0];
        efpsc_pkg::RegLength: cfg_q.length_value <= pwdata[7:0];
        efpsc_pkg::RegFrame:  cfg_q.frame_bytes  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      efpsc_pkg::RegSync:   prdata = {24'd0, cfg_q.sync_value};
      efpsc_pkg::RegId:     prdata = {24'd0, cfg_q.id_value};
      efpsc_pkg::RegLength: prdata = {24'd0, cfg_q.length_value};
      efpsc_pkg::RegFrame:  prdata = {23'd0, cfg_q.frame_bytes};
      default:              prdata = '0;
    endcase
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  efpsc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.computed_sum, out_q.position, out_q.data_byte};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

endmodule

/* hdl/efpsc_parser.sv */
module efpsc_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  efpsc_pkg::cfg_t   cfg_i,
  output logic              res_valid_o,
  output efpsc_pkg::result_t res_o
);

  efpsc_pkg::phase_e phase_q, phase_d;
  logic [8:0] count_q, count_d;
  logic       esc_q, esc_d;
  logic [7:0] sum_q, sum_d;

  logic [8:0] frame_eff;
  logic [7:0] value;
  logic [8:0] count_inc;
  logic [9:0] count_end;
  logic [7:0] sum_inc;

  always_comb begin
    if (cfg_i.frame_bytes < 9'(efpsc_pkg::MinFrame)) begin
      frame_eff = 9'(efpsc_pkg::MinFrame);
    end else if (cfg_i.frame_bytes > 9'(efpsc_pkg::MaxFrame)) begin
      frame_eff = 9'(efpsc_pkg::MaxFrame);
    end else begin
      frame_eff = cfg_i.frame_bytes;
    end
  end

  assign value     = (esc_q && byte_i == 8'h00) ? efpsc_pkg::StuffedSync : byte_i;
  assign count_inc = count_q + 9'd1;
  assign count_end = {1'b0, count_inc} + 10'd1;
  assign sum_inc   = sum_q + value;

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    esc_d       = esc_q;
    sum_d       = sum_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: efpsc_pkg::KindPayload, data_byte: value,
                    position: count_q[7:0], computed_sum: sum_inc, last: 1'b0};
    case (phase_q)
      efpsc_pkg::PhHunt: begin
        if (byte_i == cfg_i.sync_value) begin
          phase_d = efpsc_pkg::PhSync;
          count_d = 9'd1;
        end
      end
      efpsc_pkg::PhSync: begin
        if (byte_i == cfg_i.id_value) begin
          phase_d = efpsc_pkg::PhId;
          count_d = 9'd2;
        end else begin
          phase_d = efpsc_pkg::PhHunt;
          count_d = '0;
          esc_d   = 1'b0;
          sum_d   = '0;
        end
      end
      efpsc_pkg::PhId: begin
        if (byte_i == cfg_i.length_value) begin
          phase_d = efpsc_pkg::PhPayload;
          count_d = 9'd3;
        end else begin
          phase_d = efpsc_pkg::PhHunt;
          count_d = '0;
        end
        esc_d = 1'b0;
        sum_d = '0;
      end
      efpsc_pkg::PhPayload: begin
        if (!esc_q && byte_i == efpsc_pkg::EscByte) begin
          esc_d = 1'b1;
        end else begin
          esc_d       = 1'b0;
          sum_d       = sum_inc;
          count_d     = count_inc;
          res_valid_o = 1'b1;
          if (count_end >= {1'b0, frame_eff}) begin
            phase_d = efpsc_pkg::PhCheck;
          end
        end
      end
      efpsc_pkg::PhCheck: begin
        res_valid_o        = 1'b1;
        res_o.kind         = (byte_i == sum_q) ? efpsc_pkg::KindGood : efpsc_pkg::KindBad;
        res_o.data_byte    = byte_i;
        res_o.computed_sum = sum_q;
        res_o.last         = 1'b1;
        phase_d            = efpsc_pkg::PhHunt;
        count_d            = '0;
        esc_d              = 1'b0;
        sum_d              = '0;
      end
      default: begin
        phase_d = efpsc_pkg::PhHunt;
        count_d = '0;
        esc_d   = 1'b0;
        sum_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= efpsc_pkg::PhHunt;
      count_q <= '0;
      esc_q   <= 1'b0;
      sum_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      esc_q   <= esc_d;
      sum_q   <= sum_d;
    end
  end

endmodule

/* tb/frame_beat_checker.sv */
`timescale 1ns / 100ps

module frame_beat_checker import efpsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [23:0]          m_axis_tdata,   // [7:0] data_byte, [15:8] position,
                                               // [23:16] computed_sum
  input  logic [1:0]           m_axis_tuser,   // [1:0] kind
  input  logic                 m_axis_tlast,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  input  logic                 pready,
  output int                   mismatch_cnt_o,
  output int                   parsed_left_o
);

  cfg_t       cfg_q;
  phase_e     phase_q;
  logic [8:0] count_q;
  logic       esc_q;
  logic [7:0] sum_q;
  result_t    parsed_q[$];
  int         mismatches;

  function automatic void restart_hunt();
    phase_q = PhHunt;
    count_q = '0;
    esc_q   = 1'b0;
    sum_q   = '0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    logic [7:0] v;
    logic [9:0] span;
    bit         emit;
    emit = 1'b0;
    r    = '0;
    span = 10'(cfg_q.frame_bytes);
    if (span < 10'(MinFrame)) span = 10'(MinFrame);
    if (span > 10'(MaxFrame)) span = 10'(MaxFrame);
    case (phase_q)
      PhHunt: begin
        if (b == cfg_q.sync_value) begin
          phase_q = PhSync;
          count_q = 9'd1;
        end
      end
      PhSync: begin
        if (b == cfg_q.id_value) begin
          phase_q = PhId;
          count_q = 9'd2;
        end else begin
          restart_hunt();
        end
      end
      PhId: begin
        if (b == cfg_q.length_value) begin
          phase_q = PhPayload;
          count_q = 9'd3;
          sum_q   = '0;
          esc_q   = 1'b0;
        end else begin
          restart_hunt();
        end
      end
      PhPayload: begin
        if (!esc_q && b == EscByte) begin
          esc_q = 1'b1;
        end else begin
          v              = (esc_q && b == 8'h00) ? StuffedSync : b;
          esc_q          = 1'b0;
          sum_q          = sum_q + v;
          r.kind         = KindPayload;
          r.data_byte    = v;
          r.position     = count_q[7:0];
          r.computed_sum = sum_q;
          r.last         = 1'b0;
          count_q        = count_q + 9'd1;
          if ({1'b0, count_q} + 10'd1 >= span) phase_q = PhCheck;
          emit = 1'b1;
        end
      end
      PhCheck: begin
        if (b == sum_q) begin
          r.kind = KindGood;
        end else begin
          r.kind = KindBad;
        end
        r.data_byte    = b;
        r.position     = count_q[7:0];
        r.computed_sum = sum_q;
        r.last         = 1'b1;
        restart_hunt();
        emit = 1'b1;
      end
      default: restart_hunt();
    endcase
    return emit;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t beat;
    if (!rst_ni) begin
      cfg_q = {SyncReset, IdReset, LengthReset, FrameReset};
      restart_hunt();
      parsed_q.delete();
      mismatches = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (parsed_q.size() == 0) begin
          $error("output beat with nothing due: tdata 0x%0h tuser 0x%0h",
                 m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = parsed_q.pop_front();
          check_field("kind", 8'(want.kind), 8'(m_axis_tuser));
          check_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
          check_field("position", want.position, m_axis_tdata[15:8]);
          check_field("computed_sum", want.computed_sum, m_axis_tdata[23:16]);
          check_field("last", 8'(want.last), 8'(m_axis_tlast));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[AddrWidth-1:2]))
          RegSync:   cfg_q.sync_value   = pwdata[7:0];
          RegId:     cfg_q.id_value     = pwdata[7:0];
          RegLength: cfg_q.length_value = pwdata[7:0];
          RegFrame:  cfg_q.frame_bytes  = pwdata[8:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (parse_byte(s_axis_tdata, beat)) parsed_q.push_back(beat);
      end
    end
    mismatch_cnt_o <= mismatches;
    parsed_left_o  <= parsed_q.size();
  end

endmodule

/* tb/escaped_frame_parser_sum_check_tb.sv */
`timescale 1ns / 100ps

module escaped_frame_parser_sum_check_tb;
  import efpsc_pkg::*;

  localparam int unsigned HoldCycles = 80;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [AddrWidth-1:0] paddr         = '0;
  logic [31:0]          pwdata        = '0;
  logic [31:0]          prdata;
  logic                 pready;

  int          mismatch_cnt;
  int          parsed_left;
  int          idle_pct    = 30;
  int          hold_req    = 0;
  int unsigned sent_cnt    = 0;
  int unsigned frame_cnt   = 0;
  int unsigned setting_cnt = 0;
  logic [7:0]  sync_v      = SyncReset;
  logic [7:0]  id_v        = IdReset;
  logic [7:0]  len_v       = LengthReset;
  logic [8:0]  frame_v     = FrameReset;

  escaped_frame_parser_sum_check u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  frame_beat_checker u_beat_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_cnt_o (mismatch_cnt),
    .parsed_left_o  (parsed_left)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned pick_gap();
    if (idle_pct == 0 || $urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(9))
      0, 1:    return EscByte;
      2:       return StuffedSync;
      3:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned payload_len();
    int unsigned span;
    span = frame_v;
    if (span < MinFrame) span = MinFrame;
    if (span > MaxFrame) span = MaxFrame;
    return span - 4;
  endfunction

  initial begin : sink
    int unsigned low_left;
    int          holds_done;
    low_left   = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req != holds_done) begin
        holds_done = hold_req;
        low_left   = HoldCycles;
      end else if (low_left == 0) begin
        low_left = pick_gap();
      end
      if (low_left != 0) begin
        m_axis_tready <= 1'b0;
        low_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sent_cnt++;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [7:0] s, input logic [7:0] i,
                              input logic [7:0] l, input logic [8:0] f);
    write_reg(RegSync, 32'(s));
    write_reg(RegId, 32'(i));
    write_reg(RegLength, 32'(l));
    write_reg(RegFrame, 32'(f));
    sync_v  = s;
    id_v    = i;
    len_v   = l;
    frame_v = f;
    setting_cnt++;
  endtask

  // drain all due results, then cover beats still in flight that yield none
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (parsed_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_frame(input bit bad_sum);
    logic [7:0]  v;
    logic [7:0]  sum;
    int unsigned n;
    sum = '0;
    n   = payload_len();
    send_byte(sync_v);
    send_byte(id_v);
    send_byte(len_v);
    repeat (n) begin
      v   = pick_payload();
      sum = sum + v;
      if (v == EscByte || (v == StuffedSync && $urandom_range(1) == 0)) begin
        send_byte(EscByte);
        send_byte(v == EscByte ? EscByte : 8'h00);
      end else if (v != 8'h00 && $urandom_range(7) == 0) begin
        send_byte(EscByte);
        send_byte(v);
      end else begin
        send_byte(v);
      end
    end
    send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    frame_cnt++;
  endtask

  task automatic run_mix(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = sent_cnt + budget;
    while (sent_cnt < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame($urandom_range(3) == 0);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick < 87) begin
        send_byte(sync_v);
        if ($urandom_range(1) == 0) begin
          send_byte(id_v ^ 8'($urandom_range(1, 255)));
        end else begin
          send_byte(id_v);
          send_byte(len_v ^ 8'($urandom_range(1, 255)));
        end
      end else begin
        send_byte(sync_v);
        send_byte(id_v);
        send_byte(len_v);
        repeat ($urandom_range(1, 3)) send_byte(pick_payload());
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] opening[$];
    int         guard;
    opening = '{8'hA5, 8'h00, 8'h00, 8'hFF, 8'hFF,
                8'hA5, 8'h00, 8'h01,
                8'hA5, 8'hA5, 8'h00,
                8'hA5, 8'h00, 8'h00, 8'h55, 8'h00, 8'h00,
                8'hA5, 8'h00, 8'h00, 8'h55, 8'h55, 8'h55,
                8'hA5, 8'h00, 8'h00, 8'h55, 8'h12, 8'h12};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_config(8'hA5, 8'h00, 8'h00, 9'd0);
    foreach (opening[k]) send_byte(opening[k]);
    settle();

    apply_config(8'hA5, 8'h00, 8'h00, 9'd5);
    run_mix(25);
    settle();

    idle_pct <= 0;
    apply_config(8'h00, 8'hFF, 8'hFF, 9'd9);
    run_mix(25);
    settle();

    idle_pct <= 50;
    apply_config(8'hFF, 8'h3C, 8'h81, 9'd12);
    hold_req <= hold_req + 1;
    run_mix(30);
    settle();

    idle_pct <= 30;
    apply_config(8'($urandom), 8'($urandom), 8'($urandom), 9'd3);
    run_mix(25);
    settle();

    // stop inside the payload, then shrink the frame under it
    apply_config(8'hC3, 8'h5A, 8'h0F, 9'd40);
    send_byte(8'hC3);
    send_byte(8'h5A);
    send_byte(8'h0F);
    repeat (12) send_byte(8'($urandom_range(0, 8'h54)));
    settle();
    write_reg(RegFrame, 32'd6);
    frame_v = 9'd6;
    setting_cnt++;
    run_mix(15);
    settle();

    idle_pct <= 20;
    apply_config(8'h5A, 8'h11, 8'h22, 9'd511);
    hold_req <= hold_req + 1;
    send_frame(1'b0);
    settle();

    idle_pct <= 40;
    apply_config(8'($urandom), 8'($urandom), 8'($urandom), 9'd7);
    run_mix(25);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (parsed_left != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (parsed_left != 0) $error("%0d result beats never arrived", parsed_left);
    $display("Sent %0d input beats: %0d assembled frames plus noise, broken headers, cut frames.",
             sent_cnt, frame_cnt);
    $display("Covered %0d register settings, a mid-frame size change, %0d long output stalls.",
             setting_cnt, hold_req);
    if (mismatch_cnt == 0 && parsed_left == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
